>>> rtl/sector_write_verify_compare_assert.svh
// Assertion macros shared by the sector write-verify comparator.
`ifndef SECTOR_WRITE_VERIFY_COMPARE_ASSERT_SVH
`define SECTOR_WRITE_VERIFY_COMPARE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SWVC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SWVC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/swvc_pkg.sv
// Package with types, constants and the CRC step of the write-verify comparator.
package swvc_pkg;

    localparam int MAX_BYTES = 65536;
    localparam int CNT_WIDTH = 17;
    localparam int CNT_WIDTH_MAX = 131071;
    localparam int CNT_LIMIT_INT = (MAX_BYTES < CNT_WIDTH_MAX) ? MAX_BYTES : CNT_WIDTH_MAX;
    localparam logic [CNT_WIDTH-1:0] CNT_LIMIT = CNT_WIDTH'(CNT_LIMIT_INT);
    localparam logic [CNT_WIDTH-1:0] OFFSET_MAX = 17'd65535;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    localparam logic [CNT_WIDTH-1:0] MAX_LOGGED_RESET = 17'd100;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    typedef enum logic
    {
        KIND_MISMATCH = 1'b0,
        KIND_SUMMARY  = 1'b1
    } kind_t;

    typedef enum logic
    {
        STATUS_OK       = 1'b0,
        STATUS_MISMATCH = 1'b1
    } status_t;

    typedef struct packed
    {
        logic [7:0] expected_byte;
        logic [7:0] actual_byte;
        logic       last_byte;
    } pair_t;

    typedef struct packed
    {
        kind_t                record_kind;
        logic [15:0]          byte_offset;
        logic [7:0]           expected_value;
        logic [7:0]           actual_value;
        logic [7:0]           difference_bits;
        logic [31:0]          crc_of_expected;
        logic [31:0]          crc_of_actual;
        logic                 crc_agree;
        logic [CNT_WIDTH-1:0] matching_total;
        logic [CNT_WIDTH-1:0] mismatch_total;
        status_t              verify_status;
        logic                 last;
    } result_t;

    // Up to two results written into the queue in one cycle.
    typedef struct packed
    {
        logic [1:0] n;
        result_t    rec_a;
        result_t    rec_b;
    } push_t;

    typedef struct packed
    {
        logic room2;
    } queue_stat_t;

    typedef struct packed
    {
        logic sector_open;
    } core_stat_t;

    // One byte of a reflected CRC-32, bit by bit.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    function automatic logic [CNT_WIDTH-1:0] sat_inc(input logic [CNT_WIDTH-1:0] v);
        return (v < CNT_LIMIT) ? v + 17'd1 : CNT_LIMIT;
    endfunction

endpackage

>>> rtl/swvc_if.sv
// Handshake interfaces for the byte-pair requests and the result records.
interface swvc_pair_if;
    logic       valid;
    logic       ready;
    logic [7:0] expected_byte;
    logic [7:0] actual_byte;
    logic       last_byte;

    modport source (output valid, output expected_byte, output actual_byte,
                    output last_byte, input ready);
    modport sink (input valid, input expected_byte, input actual_byte,
                  input last_byte, output ready);
endinterface

interface swvc_result_if;
    logic        valid;
    logic        ready;
    logic        record_kind;
    logic [15:0] byte_offset;
    logic [7:0]  expected_value;
    logic [7:0]  actual_value;
    logic [7:0]  difference_bits;
    logic [31:0] crc_of_expected;
    logic [31:0] crc_of_actual;
    logic        crc_agree;
    logic [16:0] matching_total;
    logic [16:0] mismatch_total;
    logic        verify_status;
    logic        last;

    modport source (output valid, output record_kind, output byte_offset,
                    output expected_value, output actual_value, output difference_bits,
                    output crc_of_expected, output crc_of_actual, output crc_agree,
                    output matching_total, output mismatch_total, output verify_status,
                    output last, input ready);
    modport sink (input valid, input record_kind, input byte_offset,
                  input expected_value, input actual_value, input difference_bits,
                  input crc_of_expected, input crc_of_actual, input crc_agree,
                  input matching_total, input mismatch_total, input verify_status,
                  input last, output ready);
endinterface

>>> rtl/sector_write_verify_compare.sv
// Top level of the sector write-verify comparator.
// The block compares the bytes written to a sector with the bytes read back.
// Each request on byte_pair carries the written byte, the read-back byte and
// a flag on the last byte of the sector. Results leave on the result channel:
// a mismatch record for a differing byte while fewer than max_logged
// mismatches have been seen in the sector, and a summary with both CRC-32
// values, the byte counts and the status after the last byte. The field last
// marks the final result caused by one request.
// A request is registered in the input register when it is accepted and is worked on
// by the core once two queue entries are free; its results leave through the queue.
// One request per cycle is taken as long as each gives at most one result and the
// receiver takes the results; the output sends one result per cycle, so requests that
// give two are held back once the four-entry result queue runs short of room.
// The byte-wide CRC update is the longest path between registers.
// Reset clears the CRCs to all ones, the counters to zero, the queue to empty
// and sets max_logged to 100; no clearing pass is needed.
// When the receiver stalls, results wait in the queue and requests are
// refused only when fewer than two queue entries are free.
// max_logged is to be written through cfg_wr_en and cfg_wr_data only while idle; the block does not enforce it.
`include "sector_write_verify_compare_assert.svh"

module sector_write_verify_compare
    import swvc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CNT_WIDTH-1:0] cfg_wr_data,
    swvc_pair_if.sink            byte_pair,
    swvc_result_if.source        result
);

    logic [CNT_WIDTH-1:0] max_logged_reg;
    logic                 item_valid;
    pair_t                item;
    logic                 fire;
    push_t                push;
    queue_stat_t          qstat;
    core_stat_t           cstat;
    logic                 double_order_ok;

    // The limit register; it is to be written only while no request is in flight, which the block does not enforce.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_logged_reg <= MAX_LOGGED_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_logged_reg <= cfg_wr_data;
        end
    end

    swvc_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_pair  (byte_pair),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    swvc_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .max_logged (max_logged_reg),
        .item_valid (item_valid),
        .item       (item),
        .qstat      (qstat),
        .fire       (fire),
        .push       (push),
        .stat       (cstat)
    );

    swvc_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .qstat  (qstat),
        .result (result)
    );

    assign double_order_ok = (push.rec_a.record_kind == KIND_MISMATCH) && !push.rec_a.last
                             && (push.rec_b.record_kind == KIND_SUMMARY) && push.rec_b.last;

    // The core only writes the queue when two entries are free.
    `SWVC_ASSERT_NOW(a_push_has_room, push.n != 2'd0, qstat.room2, "queue written without room")

    // A double write is a mismatch record followed by the closing summary.
    `SWVC_ASSERT_NOW(a_double_order, push.n == 2'd2, double_order_ok, "bad record order")

    // The last byte of a sector leaves the sector state cleared.
    `SWVC_ASSERT_NEXT(a_sector_clears, fire && item.last_byte, !cstat.sector_open, "sector not cleared")

endmodule

>>> rtl/swvc_in_reg.sv
// Input register that holds one byte pair until the core takes it.
module swvc_in_reg
    import swvc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    swvc_pair_if.sink   byte_pair,
    input  logic        take,
    output logic        item_valid,
    output pair_t       item
);

    logic  valid_reg;
    logic  valid_next;
    pair_t item_reg;
    logic  accept;

    assign byte_pair.ready = !valid_reg || take;
    assign accept = byte_pair.valid && byte_pair.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= '{expected_byte: byte_pair.expected_byte,
                          actual_byte:   byte_pair.actual_byte,
                          last_byte:     byte_pair.last_byte};
        end
    end

    assign item_valid = valid_reg;
    assign item = item_reg;

endmodule

>>> rtl/swvc_core.sv
// Sector state: running CRCs, counters and formation of the result records.
module swvc_core
    import swvc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [CNT_WIDTH-1:0] max_logged,
    input  logic                 item_valid,
    input  pair_t                item,
    input  queue_stat_t          qstat,
    output logic                 fire,
    output push_t                push,
    output core_stat_t           stat
);

    logic [31:0]          crc_e_reg;
    logic [31:0]          crc_e_next;
    logic [31:0]          crc_a_reg;
    logic [31:0]          crc_a_next;
    logic [CNT_WIDTH-1:0] position_reg;
    logic [CNT_WIDTH-1:0] position_next;
    logic [CNT_WIDTH-1:0] equal_reg;
    logic [CNT_WIDTH-1:0] equal_next;
    logic [CNT_WIDTH-1:0] differ_reg;
    logic [CNT_WIDTH-1:0] differ_next;

    logic [31:0]          crc_e_upd;
    logic [31:0]          crc_a_upd;
    logic [CNT_WIDTH-1:0] equal_upd;
    logic [CNT_WIDTH-1:0] differ_upd;
    logic [CNT_WIDTH-1:0] offset_sat;
    logic                 mismatch;
    logic                 log_it;
    result_t              mis_rec;
    result_t              sum_rec;

    assign fire = item_valid && qstat.room2;

    assign crc_e_upd = crc32_byte(crc_e_reg, item.expected_byte);
    assign crc_a_upd = crc32_byte(crc_a_reg, item.actual_byte);
    assign mismatch = item.expected_byte != item.actual_byte;
    assign log_it = mismatch && (differ_reg < max_logged);
    assign equal_upd = mismatch ? equal_reg : sat_inc(equal_reg);
    assign differ_upd = mismatch ? sat_inc(differ_reg) : differ_reg;
    assign offset_sat = (position_reg < OFFSET_MAX) ? position_reg : OFFSET_MAX;

    always_comb
    begin
        mis_rec = '0;
        mis_rec.record_kind = KIND_MISMATCH;
        mis_rec.byte_offset = offset_sat[15:0];
        mis_rec.expected_value = item.expected_byte;
        mis_rec.actual_value = item.actual_byte;
        mis_rec.difference_bits = item.expected_byte ^ item.actual_byte;
        mis_rec.verify_status = STATUS_OK;
        mis_rec.last = !item.last_byte;

        sum_rec = '0;
        sum_rec.record_kind = KIND_SUMMARY;
        sum_rec.crc_of_expected = ~crc_e_upd;
        sum_rec.crc_of_actual = ~crc_a_upd;
        sum_rec.crc_agree = crc_e_upd == crc_a_upd;
        sum_rec.matching_total = equal_upd;
        sum_rec.mismatch_total = differ_upd;
        sum_rec.verify_status = (differ_upd != '0) ? STATUS_MISMATCH : STATUS_OK;
        sum_rec.last = 1'b1;
    end

    // A logged mismatch always goes first; the summary follows it on the last byte.
    always_comb
    begin
        push.rec_a = log_it ? mis_rec : sum_rec;
        push.rec_b = sum_rec;
        if (!fire)
        begin
            push.n = 2'd0;
        end
        else
        begin
            push.n = {1'b0, log_it} + {1'b0, item.last_byte};
        end
    end

    always_comb
    begin
        crc_e_next = crc_e_reg;
        crc_a_next = crc_a_reg;
        position_next = position_reg;
        equal_next = equal_reg;
        differ_next = differ_reg;
        if (fire)
        begin
            if (item.last_byte)
            begin
                crc_e_next = CRC_INIT;
                crc_a_next = CRC_INIT;
                position_next = '0;
                equal_next = '0;
                differ_next = '0;
            end
            else
            begin
                crc_e_next = crc_e_upd;
                crc_a_next = crc_a_upd;
                position_next = sat_inc(position_reg);
                equal_next = equal_upd;
                differ_next = differ_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_e_reg <= CRC_INIT;
            crc_a_reg <= CRC_INIT;
            position_reg <= '0;
            equal_reg <= '0;
            differ_reg <= '0;
        end
        else
        begin
            crc_e_reg <= crc_e_next;
            crc_a_reg <= crc_a_next;
            position_reg <= position_next;
            equal_reg <= equal_next;
            differ_reg <= differ_next;
        end
    end

    assign stat.sector_open = position_reg != '0;

endmodule

>>> rtl/swvc_queue.sv
// Small result queue that takes up to two records a cycle and sends one while the receiver is ready.
module swvc_queue
    import swvc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  push_t         push,
    output queue_stat_t   qstat,
    swvc_result_if.source result
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] ROOM_LIMIT = CW'(QUEUE_DEPTH - 2);

    result_t         mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [PW-1:0]   wr_ptr_p1;
    logic [PW-1:0]   wr_ptr_p2;
    logic            pop;
    result_t         head;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + PW'(1);
    endfunction

    assign wr_ptr_p1 = wrap_inc(wr_ptr_reg);
    assign wr_ptr_p2 = wrap_inc(wr_ptr_p1);
    assign pop = result.valid && result.ready;
    assign qstat.room2 = count_reg <= ROOM_LIMIT;

    always_comb
    begin
        rd_ptr_next = pop ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next = count_reg + CW'(push.n) - CW'(pop);
        unique case (push.n)
            2'd1:    wr_ptr_next = wr_ptr_p1;
            2'd2:    wr_ptr_next = wr_ptr_p2;
            default: wr_ptr_next = wr_ptr_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.rec_a;
        end
        if (push.n == 2'd2)
        begin
            mem_reg[wr_ptr_p1] <= push.rec_b;
        end
    end

    assign head = mem_reg[rd_ptr_reg];

    assign result.valid = count_reg != '0;
    assign result.record_kind = head.record_kind;
    assign result.byte_offset = head.byte_offset;
    assign result.expected_value = head.expected_value;
    assign result.actual_value = head.actual_value;
    assign result.difference_bits = head.difference_bits;
    assign result.crc_of_expected = head.crc_of_expected;
    assign result.crc_of_actual = head.crc_of_actual;
    assign result.crc_agree = head.crc_agree;
    assign result.matching_total = head.matching_total;
    assign result.mismatch_total = head.mismatch_total;
    assign result.verify_status = head.verify_status;
    assign result.last = head.last;

endmodule

>>> dv/sector_write_verify_compare_tb.sv
// Self-checking testbench for the sector write-verify comparator.
`timescale 1ns / 100ps

module sector_write_verify_compare_tb;

    import swvc_pkg::*;

    // The first result of a request passes the input register and then the result
    // queue, so the extra drain cycles cover any request that is still in flight.
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_REQUESTS = 250;

    // One row of stimulus. When typed_count is not negative, the results of
    // the row are written out by hand in typed_first and typed_second;
    // otherwise the results come from the predictor.
    typedef struct
    {
        pair_t   pair;
        int      typed_count;
        result_t typed_first;
        result_t typed_second;
    } stim_row_t;

    localparam result_t NO_RESULT = '0;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CNT_WIDTH-1:0] cfg_wr_data;

    swvc_pair_if   pair_ch ();
    swvc_result_if result_ch ();

    sector_write_verify_compare dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .byte_pair   (pair_ch),
        .result      (result_ch)
    );

    // Requests waiting to be offered, and results the block still owes us.
    stim_row_t request_q [$];
    result_t   owed_results [$];
    stim_row_t on_bus;
    int        requests_left;
    int        fault_count;
    int        result_index;
    int        sender_idle_pct;
    int        receiver_stall_pct;

    // Our own copy of the comparator state and of the max_logged register.
    logic [31:0]          crc_written;
    logic [31:0]          crc_read;
    logic [CNT_WIDTH-1:0] sector_pos;
    logic [CNT_WIDTH-1:0] equal_bytes;
    logic [CNT_WIDTH-1:0] differ_bytes;
    logic [CNT_WIDTH-1:0] log_limit;

    stim_row_t directed_table [$];

    // ------------------------------------------------------------------
    // Clock and the run limit.
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // The slowest correct run, with two results per request and the
    // heaviest stalls, still ends well before this limit.
    initial
    begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor.
    // ------------------------------------------------------------------

    // Reflected CRC-32, one data bit at a time, LSB first.
    function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc;
        for (int k = 0; k < 8; k++)
        begin
            if (c[0] ^ data[k])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // Counters stop at the saturation limit instead of wrapping.
    function automatic logic [CNT_WIDTH-1:0] count_up(input logic [CNT_WIDTH-1:0] v);
        return (v == CNT_LIMIT) ? v : v + 1'b1;
    endfunction

    function automatic void clear_sector_state();
        crc_written  = CRC_INIT;
        crc_read     = CRC_INIT;
        sector_pos   = '0;
        equal_bytes  = '0;
        differ_bytes = '0;
    endfunction

    // Advances the model by one byte pair and returns how many results it
    // gives, in order, through first and second.
    function automatic int compare_byte_pair(input pair_t p, output result_t first,
                                             output result_t second);
        result_t r;
        int      n;
        n      = 0;
        first  = NO_RESULT;
        second = NO_RESULT;
        crc_written = crc_feed(crc_written, p.expected_byte);
        crc_read    = crc_feed(crc_read, p.actual_byte);
        if (p.expected_byte == p.actual_byte)
        begin
            equal_bytes = count_up(equal_bytes);
        end
        else
        begin
            // A record goes out only while the sector's mismatch count is
            // still under the limit; the count itself keeps going.
            if (differ_bytes < log_limit)
            begin
                r                 = NO_RESULT;
                r.record_kind     = KIND_MISMATCH;
                r.byte_offset     = (sector_pos < OFFSET_MAX) ? sector_pos[15:0] : 16'hFFFF;
                r.expected_value  = p.expected_byte;
                r.actual_value    = p.actual_byte;
                r.difference_bits = p.expected_byte ^ p.actual_byte;
                r.last            = !p.last_byte;
                first = r;
                n     = 1;
            end
            differ_bytes = count_up(differ_bytes);
        end
        sector_pos = count_up(sector_pos);
        if (p.last_byte)
        begin
            r                 = NO_RESULT;
            r.record_kind     = KIND_SUMMARY;
            r.crc_of_expected = ~crc_written;
            r.crc_of_actual   = ~crc_read;
            r.crc_agree       = (crc_written == crc_read);
            r.matching_total  = equal_bytes;
            r.mismatch_total  = differ_bytes;
            r.verify_status   = (differ_bytes != 0) ? STATUS_MISMATCH : STATUS_OK;
            r.last            = 1'b1;
            if (n == 0)
                first = r;
            else
                second = r;
            n++;
            clear_sector_state();
        end
        return n;
    endfunction

    // ------------------------------------------------------------------
    // Building stimulus rows.
    // ------------------------------------------------------------------
    function automatic result_t mismatch_rec(input logic [15:0] offset, input logic [7:0] wr,
                                             input logic [7:0] rd, input logic [7:0] diff,
                                             input logic last_flag);
        result_t r;
        r                 = NO_RESULT;
        r.record_kind     = KIND_MISMATCH;
        r.byte_offset     = offset;
        r.expected_value  = wr;
        r.actual_value    = rd;
        r.difference_bits = diff;
        r.last            = last_flag;
        return r;
    endfunction

    function automatic result_t summary_rec(input logic [31:0] crc_wr, input logic [31:0] crc_rd,
                                            input logic agree, input logic [16:0] equal_total,
                                            input logic [16:0] differ_total, input status_t st);
        result_t r;
        r                 = NO_RESULT;
        r.record_kind     = KIND_SUMMARY;
        r.crc_of_expected = crc_wr;
        r.crc_of_actual   = crc_rd;
        r.crc_agree       = agree;
        r.matching_total  = equal_total;
        r.mismatch_total  = differ_total;
        r.verify_status   = st;
        r.last            = 1'b1;
        return r;
    endfunction

    function automatic stim_row_t table_row(input logic [7:0] wr, input logic [7:0] rd,
                                            input logic last_flag, input int count,
                                            input result_t f0, input result_t f1);
        stim_row_t row;
        row.pair.expected_byte = wr;
        row.pair.actual_byte   = rd;
        row.pair.last_byte     = last_flag;
        row.typed_count        = count;
        row.typed_first        = f0;
        row.typed_second       = f1;
        return row;
    endfunction

    task automatic queue_row(input stim_row_t row);
        request_q.push_back(row);
        requests_left++;
    endtask

    // ------------------------------------------------------------------
    // Checking.
    // ------------------------------------------------------------------
    task automatic log_fault(input string msg);
        if (fault_count < 100)
            $display("ERROR @%0t: %s", $realtime, msg);
        fault_count++;
    endtask

    task automatic check_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            log_fault($sformatf("result %0d: %s is %0h, expected %0h",
                                result_index, field, got, want));
    endtask

    task automatic check_result();
        result_t want;
        if (owed_results.size() == 0)
        begin
            log_fault($sformatf("result %0d arrived with nothing expected", result_index));
        end
        else
        begin
            want = owed_results.pop_front();
            check_field("record_kind", 32'(result_ch.record_kind), 32'(want.record_kind));
            check_field("byte_offset", 32'(result_ch.byte_offset), 32'(want.byte_offset));
            check_field("expected_value", 32'(result_ch.expected_value),
                        32'(want.expected_value));
            check_field("actual_value", 32'(result_ch.actual_value), 32'(want.actual_value));
            check_field("difference_bits", 32'(result_ch.difference_bits),
                        32'(want.difference_bits));
            check_field("crc_of_expected", result_ch.crc_of_expected, want.crc_of_expected);
            check_field("crc_of_actual", result_ch.crc_of_actual, want.crc_of_actual);
            check_field("crc_agree", 32'(result_ch.crc_agree), 32'(want.crc_agree));
            check_field("matching_total", 32'(result_ch.matching_total),
                        32'(want.matching_total));
            check_field("mismatch_total", 32'(result_ch.mismatch_total),
                        32'(want.mismatch_total));
            check_field("verify_status", 32'(result_ch.verify_status), 32'(want.verify_status));
            check_field("last", 32'(result_ch.last), 32'(want.last));
        end
        result_index++;
    endtask

    // A request that went through: the predictor always advances, and the
    // typed results stand in for the predicted ones on rows that carry them.
    task automatic take_request(input stim_row_t row);
        result_t p0;
        result_t p1;
        int      n;
        n = compare_byte_pair(row.pair, p0, p1);
        if (row.typed_count >= 0)
        begin
            n  = row.typed_count;
            p0 = row.typed_first;
            p1 = row.typed_second;
        end
        if (n > 0)
            owed_results.push_back(p0);
        if (n > 1)
            owed_results.push_back(p1);
        requests_left--;
    endtask

    // ------------------------------------------------------------------
    // Request driver. Everything is sampled and driven at the rising edge;
    // the acceptance check reads the values from before the edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pair_ch.valid && pair_ch.ready)
                take_request(on_bus);
            // Only one nonblocking write to valid per edge: a request that
            // follows straight on keeps valid high.
            if (!pair_ch.valid || pair_ch.ready)
            begin
                if (request_q.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    on_bus = request_q.pop_front();
                    pair_ch.valid         <= 1'b1;
                    pair_ch.expected_byte <= on_bus.pair.expected_byte;
                    pair_ch.actual_byte   <= on_bus.pair.actual_byte;
                    pair_ch.last_byte     <= on_bus.pair.last_byte;
                end
                else
                begin
                    pair_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver with random back-pressure.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            check_result();
        result_ch.ready <= rst_n && ($urandom_range(99) >= receiver_stall_pct);
    end

    // ------------------------------------------------------------------
    // Sequencing helpers.
    // ------------------------------------------------------------------

    // Waits until every request is taken and every result is in, then lets
    // the block settle; a request that gives no result may still be in
    // flight behind the last result.
    task automatic wait_drained();
        while (requests_left != 0 || owed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write, done only while the block is idle.
    task automatic write_max_logged(input logic [CNT_WIDTH-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        log_limit = value;
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        int                   limits [RANDOM_PHASES];
        int                   differ_pcts [4];
        int                   queued;
        int                   len;
        int                   differ_pct;
        logic [7:0]           wr;
        logic [7:0]           rd;

        // Every input gets a known value before the first edge.
        rst_n                 = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_wr_data           = '0;
        pair_ch.valid         = 1'b0;
        pair_ch.expected_byte = '0;
        pair_ch.actual_byte   = '0;
        pair_ch.last_byte     = 1'b0;
        result_ch.ready       = 1'b0;
        requests_left         = 0;
        fault_count           = 0;
        result_index          = 0;
        sender_idle_pct       = 0;
        receiver_stall_pct    = 0;
        log_limit             = MAX_LOGGED_RESET;
        clear_sector_state();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, run with the reset value of max_logged and no
        // idling. The CRC of a lone 0x00 byte is D202EF8D and that of a lone
        // 0xFF byte is FF000000, so the one-byte sectors are typed in.
        directed_table = '{
            // Matching one-byte sector straight after reset.
            table_row(8'h00, 8'h00, 1'b1, 1, summary_rec(32'hD202EF8D, 32'hD202EF8D,
                      1'b1, 17'd1, 17'd0, STATUS_OK), NO_RESULT),
            // All bits differ on the last and only byte: record, then summary.
            table_row(8'hFF, 8'h00, 1'b1, 2, mismatch_rec(16'd0, 8'hFF, 8'h00, 8'hFF, 1'b0),
                      summary_rec(32'hFF000000, 32'hD202EF8D, 1'b0, 17'd0, 17'd1,
                      STATUS_MISMATCH)),
            table_row(8'hFF, 8'hFF, 1'b1, 1, summary_rec(32'hFF000000, 32'hFF000000,
                      1'b1, 17'd1, 17'd0, STATUS_OK), NO_RESULT),
            // Multi-byte sector with mismatches inside it.
            table_row(8'h55, 8'hAA, 1'b0, 1, mismatch_rec(16'd0, 8'h55, 8'hAA, 8'hFF, 1'b1),
                      NO_RESULT),
            table_row(8'h12, 8'h12, 1'b0, 0, NO_RESULT, NO_RESULT),
            table_row(8'h80, 8'h01, 1'b0, 1, mismatch_rec(16'd2, 8'h80, 8'h01, 8'h81, 1'b1),
                      NO_RESULT),
            table_row(8'h01, 8'h01, 1'b1, -1, NO_RESULT, NO_RESULT),
            // Mismatch on the last byte of a longer sector.
            table_row(8'hA5, 8'h5A, 1'b0, 1, mismatch_rec(16'd0, 8'hA5, 8'h5A, 8'hFF, 1'b1),
                      NO_RESULT),
            table_row(8'h00, 8'h01, 1'b1, -1, NO_RESULT, NO_RESULT),
            // Single-bit and complementary differences.
            table_row(8'h7F, 8'h80, 1'b0, 1, mismatch_rec(16'd0, 8'h7F, 8'h80, 8'hFF, 1'b1),
                      NO_RESULT),
            table_row(8'h01, 8'h03, 1'b0, 1, mismatch_rec(16'd1, 8'h01, 8'h03, 8'h02, 1'b1),
                      NO_RESULT),
            table_row(8'h40, 8'h40, 1'b0, 0, NO_RESULT, NO_RESULT),
            table_row(8'h0F, 8'hF0, 1'b0, -1, NO_RESULT, NO_RESULT),
            table_row(8'hAA, 8'hAA, 1'b1, -1, NO_RESULT, NO_RESULT),
            // Clean multi-byte sector.
            table_row(8'h3C, 8'h3C, 1'b0, 0, NO_RESULT, NO_RESULT),
            table_row(8'hC3, 8'hC3, 1'b1, -1, NO_RESULT, NO_RESULT)
        };
        @(negedge clk);
        foreach (directed_table[i])
            queue_row(directed_table[i]);
        wait_drained();

        // Random part: each phase has its own max_logged value and one of four
        // idling patterns. The limits include zero, one, the extremes and a spread
        // of small values where the record cut-off is hit often.
        limits      = '{0, 1, 65535, 3, 2, 65536, 4, 100};
        limits[6]   = $urandom_range(4, 20);
        differ_pcts = '{0, 5, 30, 100};
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            write_max_logged(CNT_WIDTH'(limits[ph]));
            @(negedge clk);
            unique case (ph % 4)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 51;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 51;
                end
                default:
                begin
                    sender_idle_pct    = 14;
                    receiver_stall_pct = 14;
                end
            endcase
            // Whole sectors only, mostly short, now and then a long one.
            queued = 0;
            while (queued < PHASE_REQUESTS)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(25, 200)
                                               : $urandom_range(1, 24);
                differ_pct = differ_pcts[$urandom_range(3)];
                for (int i = 0; i < len; i++)
                begin
                    wr = 8'($urandom_range(255));
                    rd = wr;
                    if ($urandom_range(99) < differ_pct)
                    begin
                        // Flip either a single bit or a random nonzero mask.
                        if ($urandom_range(1))
                            rd = wr ^ (8'h01 << $urandom_range(7));
                        else
                            rd = wr ^ 8'($urandom_range(1, 255));
                    end
                    queue_row(table_row(wr, rd, i == len - 1, -1, NO_RESULT, NO_RESULT));
                end
                queued += len;
            end
            wait_drained();
        end

        if (fault_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/swvc_pkg.sv
rtl/swvc_if.sv
rtl/swvc_in_reg.sv
rtl/swvc_core.sv
rtl/swvc_queue.sv
rtl/sector_write_verify_compare.sv
dv/sector_write_verify_compare_tb.sv
